[rtl/core/bchisq_pkg.sv]
// Shared constants and control/status types for the byte chi-square test.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package bchisq_pkg;

	localparam int unsigned BCHISQ_MAX_LEN_DEF = 65536;
	localparam int unsigned NUM_BINS           = 256;
	localparam int unsigned BYTE_W             = 8;
	localparam int unsigned CHI_W              = 40;
	localparam int unsigned COUNT_W            = 17;
	localparam int unsigned FRAC_W             = 16;
	// The uniform expectation multiplies the sum of squares by 256.
	localparam int unsigned SCALE_SHIFT        = 8;

	// Counter width that holds every count up to max_len inclusive.
	function automatic int unsigned cnt_width(input int unsigned max_len);
		int unsigned w;
		w = 1;
		while ((64'd1 << w) <= 64'(max_len)) begin
			w = w + 1;
		end
		return w;
	endfunction

	typedef struct packed {
		logic take;      // input transaction accepted this cycle
		logic upd;       // histogram and sum update for the byte just read
		logic sqr;       // register len*len
		logic div_start; // load the divider with the scaled numerator
		logic out_load;  // capture the result and clear the block state
	} bchisq_cmd_t;

	typedef struct packed {
		logic full;      // byte count has reached MAX_LEN
		logic div_idle;  // divider finished or never started
		logic out_free;  // output register can take a result this cycle
	} bchisq_sts_t;

endpackage

[rtl/core/bchisq_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on bchisq_pkg for default widths.
`timescale 1ns / 1ps

module bchisq_div import bchisq_pkg::*; #(
	parameter int unsigned DIVIDEND_W = 2 * cnt_width(BCHISQ_MAX_LEN_DEF) + SCALE_SHIFT + FRAC_W,
	parameter int unsigned DIVISOR_W  = cnt_width(BCHISQ_MAX_LEN_DEF)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// The remainder stays below the divisor, so the shifted trial fits one extra bit.
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The dividend register shifts out at the top and collects quotient bits at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

[rtl/core/bchisq_dp.sv]
// Datapath: byte histogram memory, sum of squares, count, numerator and result register.
// Depends on bchisq_pkg and instantiates bchisq_div.
`timescale 1ns / 1ps

module bchisq_dp import bchisq_pkg::*; #(
	parameter int unsigned MAX_LEN = BCHISQ_MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bchisq_cmd_t        cmd,
	output bchisq_sts_t        sts,
	input  logic [BYTE_W-1:0]  sample_byte,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [CHI_W-1:0]   chi_q16,
	output logic [COUNT_W-1:0] byte_count,
	output logic               overflow_flag
);

	localparam int unsigned CW = cnt_width(MAX_LEN);
	localparam int unsigned SW = 2 * CW;
	localparam int unsigned NW = SW + SCALE_SHIFT;
	localparam int unsigned DW = NW + FRAC_W;

	logic [CW-1:0]       hist_mem [NUM_BINS];
	logic [NUM_BINS-1:0] hist_vld_q;
	logic [BYTE_W-1:0]   addr_q;
	logic [CW-1:0]       rd_cnt_s1;
	logic                rd_vld_s1;
	logic [CW-1:0]       old_cnt;
	logic [CW-1:0]       new_cnt;

	logic [CW-1:0]       len_q;
	logic [SW-1:0]       sum_q;
	logic                ovf_q;
	logic [SW-1:0]       sq_q;
	logic [NW-1:0]       numer;
	logic [DW-1:0]       quot;
	logic                div_busy;
	logic                full;
	logic [CW+COUNT_W-1:0] len_ext;

	logic [CHI_W-1:0]    chi_q;
	logic [COUNT_W-1:0]  cnt_out_q;
	logic                ovf_out_q;
	logic                out_full_q;

	// A bin whose valid bit is clear has not been touched since the last block and reads as zero.
	assign old_cnt = rd_vld_s1 ? rd_cnt_s1 : '0;
	assign new_cnt = old_cnt + 1'b1;
	assign full    = (len_q == CW'(MAX_LEN));
	assign numer   = {sum_q, SCALE_SHIFT'(0)} - NW'(sq_q);
	assign len_ext = (CW + COUNT_W)'(len_q);

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			hist_mem[addr_q] <= new_cnt;
		end
		if (cmd.take) begin
			rd_cnt_s1 <= hist_mem[sample_byte];
			rd_vld_s1 <= hist_vld_q[sample_byte];
			addr_q    <= sample_byte;
		end
		if (cmd.sqr) begin
			sq_q <= SW'(len_q) * SW'(len_q);
		end
		if (cmd.out_load) begin
			chi_q     <= (len_q == '0) ? '0 : quot[CHI_W-1:0];
			cnt_out_q <= len_ext[COUNT_W-1:0];
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			ovf_q      <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				hist_vld_q <= '0;
				len_q      <= '0;
				sum_q      <= '0;
				ovf_q      <= 1'b0;
			end else begin
				if (cmd.take && full) begin
					ovf_q <= 1'b1;
				end
				if (cmd.upd) begin
					hist_vld_q[addr_q] <= 1'b1;
					len_q              <= len_q + 1'b1;
					// (c+1)^2 - c^2 = 2c+1
					sum_q              <= sum_q + SW'({old_cnt, 1'b1});
				end
			end
			if (cmd.out_load) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	bchisq_div #(
		.DIVIDEND_W (DW),
		.DIVISOR_W  (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({numer, FRAC_W'(0)}),
		.divisor  (len_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign sts.full     = full;
	assign sts.div_idle = !div_busy;
	assign sts.out_free = !out_full_q || out_ready;

	assign out_valid     = out_full_q;
	assign chi_q16       = chi_q;
	assign byte_count    = cnt_out_q;
	assign overflow_flag = ovf_out_q;

endmodule

[rtl/core/bchisq_ctrl.sv]
// Controller state machine: sequences byte updates, the final divide and result hand-off.
// Depends on bchisq_pkg for the command and status types.
`timescale 1ns / 1ps

module bchisq_ctrl import bchisq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        last_flag,
	output logic        in_ready,
	input  bchisq_sts_t sts,
	output bchisq_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_SQR,
		ST_NUM,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						last_q <= last_flag;
						// A byte past the length limit is dropped without touching the histogram.
						if (!sts.full) begin
							state_q <= ST_UPD;
						end else if (last_flag) begin
							state_q <= ST_SQR;
						end
					end
				end
				ST_UPD: begin
					state_q <= last_q ? ST_SQR : ST_IDLE;
				end
				ST_SQR: begin
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_idle) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.upd       = (state_q == ST_UPD);
		cmd.sqr       = (state_q == ST_SQR);
		cmd.div_start = (state_q == ST_NUM);
		cmd.out_load  = (state_q == ST_DONE) && sts.out_free;
	end

endmodule

[rtl/core/byte_chi_square_test.sv]
// Top level of the byte chi-square uniformity test.
// Depends on bchisq_pkg; instantiates bchisq_ctrl and bchisq_dp.
`timescale 1ns / 1ps

// Bytes of a block arrive one per input transaction, the final one marked by last_flag.
// Each counted byte has its histogram bin read when it is taken; then the incremented
// count is written back and 2c+1 added to the sum of squares, and no new byte is taken
// until that write-back is done. An unmarked byte that arrives once MAX_LEN bytes are
// counted only sets the overflow flag. After the marked byte the block works out
// floor(65536*(256*S - L*L)/L) with a one-bit-per-cycle divider of W dividend bits,
// W = 2*clog2(MAX_LEN+1) + 24; a marked byte that arrives once the block is full skips
// the histogram update and goes straight to the squaring and the divide.
// Histogram bins are cleared at once through per-bin valid bits, so no clearing pass is
// needed. A finished result sits in an output register, and the next block can start
// while it waits to be taken.
module byte_chi_square_test import bchisq_pkg::*; #(
	parameter int unsigned MAX_LEN = BCHISQ_MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  sample_byte,
	input  logic               last_flag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHI_W-1:0]   chi_q16,
	output logic [COUNT_W-1:0] byte_count,
	output logic               overflow_flag
);

	bchisq_cmd_t cmd;
	bchisq_sts_t sts;

	bchisq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_flag (last_flag),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bchisq_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.sample_byte   (sample_byte),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.chi_q16       (chi_q16),
		.byte_count    (byte_count),
		.overflow_flag (overflow_flag)
	);

	// No byte is taken while the divider is still working on the previous block.
	a_no_take_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> sts.div_idle)
		else $error("input accepted while divider busy");

	// A result is never written over one that has not been taken.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	// The histogram is never updated once the length limit is reached.
	a_no_count_past_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> !sts.full)
		else $error("byte counted past MAX_LEN");

	// The divider is started only after the squared length was registered.
	a_div_after_square: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> $past(cmd.sqr))
		else $error("divider started without fresh square");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for byte_chi_square_test: drives byte blocks and predicts each
// block's chi-square result, byte count and overflow flag. Depends on bchisq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import bchisq_pkg::*;

	localparam int unsigned TB_MAX_LEN   = BCHISQ_MAX_LEN_DEF;
	localparam int unsigned CYCLE_LIMIT  = 2000000;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct {
		logic [CHI_W-1:0]   chi;
		logic [COUNT_W-1:0] count;
		logic               ovf;
	} chi_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [BYTE_W-1:0]  sample_byte;
	logic               last_flag;
	logic               out_valid;
	logic               out_ready;
	logic [CHI_W-1:0]   chi_q16;
	logic [COUNT_W-1:0] byte_count;
	logic               overflow_flag;

	// Predicted state of the current block.
	logic [COUNT_W-1:0] hist_count [NUM_BINS];
	logic [COUNT_W-1:0] hist_bytes;
	logic [32:0]        hist_sumsq;
	logic               hist_ovf;

	chi_result_t        expected_results [$];
	int unsigned        send_idle_pct;
	int unsigned        recv_idle_pct;
	int unsigned        mismatch_count = 0;
	int unsigned        cycle_count = 0;

	byte_chi_square_test #(.MAX_LEN(TB_MAX_LEN)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_byte   (sample_byte),
		.last_flag     (last_flag),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chi_q16       (chi_q16),
		.byte_count    (byte_count),
		.overflow_flag (overflow_flag)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void clear_histogram();
		for (int i = 0; i < NUM_BINS; i++) begin
			hist_count[i] = '0;
		end
		hist_bytes = '0;
		hist_sumsq = '0;
		hist_ovf   = 1'b0;
	endfunction

	// floor(65536 * (256*S - L*L) / L), done in 64 bits as a long division in two steps.
	function automatic logic [CHI_W-1:0] chi_from_sums(input logic [32:0] s,
			input logic [COUNT_W-1:0] n);
		logic [63:0] num;
		logic [63:0] len;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] chi;
		len = 64'(n);
		if (len == 0) begin
			return '0;
		end
		num = (64'(s) << 8) - len * len;
		q   = num / len;
		r   = num % len;
		chi = (q << 16) + ((r << 16) / len);
		return chi[CHI_W-1:0];
	endfunction

	function automatic void account_byte(input logic [BYTE_W-1:0] b, input logic l);
		chi_result_t res;
		if (32'(hist_bytes) < TB_MAX_LEN) begin
			hist_sumsq     = hist_sumsq + 33'({hist_count[b], 1'b0}) + 33'd1;
			hist_count[b]  = hist_count[b] + 1'b1;
			hist_bytes     = hist_bytes + 1'b1;
		end else begin
			hist_ovf = 1'b1;
		end
		if (l) begin
			res.chi   = chi_from_sums(hist_sumsq, hist_bytes);
			res.count = hist_bytes;
			res.ovf   = hist_ovf;
			expected_results.push_back(res);
			clear_histogram();
		end
	endfunction

	// Sends one byte; in_valid is left high so back-to-back transactions need no gap.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_byte <= b;
		last_flag   <= l;
		do @(posedge clk); while (!in_ready);
		account_byte(b, l);
	endtask

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	always @(posedge clk) begin
		chi_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				flag_error($sformatf("unexpected result: chi=%0d count=%0d ovf=%0b",
					chi_q16, byte_count, overflow_flag));
			end else begin
				want = expected_results.pop_front();
				if (chi_q16 !== want.chi || byte_count !== want.count ||
						overflow_flag !== want.ovf) begin
					flag_error($sformatf(
						"mismatch: expected chi=%0d count=%0d ovf=%0b, got chi=%0d count=%0d ovf=%0b",
						want.chi, want.count, want.ovf, chi_q16, byte_count, overflow_flag));
				end
			end
		end
	end

	task automatic test_directed();
		// One-byte blocks at both byte extremes.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// Each bit set once: a perfectly spread block.
		for (int i = 0; i < BYTE_W; i++) begin
			send_byte(8'(1 << i), (i == BYTE_W - 1));
		end
		// Repeated byte: the largest statistic for its length.
		for (int i = 0; i < 8; i++) begin
			send_byte(8'h55, (i == 7));
		end
		send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	// Blocks of random length and content: uniform, clustered on a few values, or constant.
	task automatic test_random_blocks(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned mode;
		logic [BYTE_W-1:0] base;
		logic [BYTE_W-1:0] b;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 85) begin
				len = $urandom_range(24, 1);
			end else begin
				len = $urandom_range(200, 25);
			end
			mode = $urandom_range(2);
			base = 8'($urandom_range(255));
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: b = 8'($urandom_range(255));
					1: b = base ^ 8'($urandom_range(3));
					default: b = base;
				endcase
				send_byte(b, (i == len - 1));
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		sample_byte    <= '0;
		last_flag      <= 1'b0;
		send_idle_pct  = 21;
		recv_idle_pct  = 87;
		clear_histogram();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_blocks(530);

		send_idle_pct = 87;
		recv_idle_pct = 21;
		test_random_blocks(530);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_blocks(540);

		in_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[byte_chi_square_test.f]
rtl/core/bchisq_pkg.sv
rtl/core/bchisq_div.sv
rtl/core/bchisq_dp.sv
rtl/core/bchisq_ctrl.sv
rtl/core/byte_chi_square_test.sv
dv/tb_top.sv
